[rtl/s256_pkg.sv]
package s256_pkg;

  localparam int unsigned WORDS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef logic [7:0][31:0] work_t;
  typedef logic [3:0][3:0]  rd_addr_t;
  typedef logic [3:0][31:0] rd_data_t;

  typedef struct packed {
    logic       load;
    logic       sched;
    logic       step;
    logic [5:0] sidx;
  } rnd_ctl_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

[rtl/s256_wmem.sv]
module s256_wmem (
  input  logic                clk,
  input  logic                we,
  input  logic [3:0]          waddr,
  input  logic [31:0]         wdata,
  input  s256_pkg::rd_addr_t  raddr,
  output s256_pkg::rd_data_t  rdata
);
  import s256_pkg::*;

  // two identical copies give four read ports for the message schedule
  logic [31:0] mem_a [WORDS];
  logic [31:0] mem_b [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
    end
    rdata[0] <= mem_a[raddr[0]];
    rdata[1] <= mem_a[raddr[1]];
    rdata[2] <= mem_b[raddr[2]];
    rdata[3] <= mem_b[raddr[3]];
  end

endmodule

[rtl/s256_round.sv]
module s256_round (
  input  logic                clk,
  input  s256_pkg::rnd_ctl_t  ctl,
  input  s256_pkg::work_t     h,
  input  s256_pkg::rd_data_t  rd,
  output logic [31:0]         wt,
  output s256_pkg::work_t     v
);
  import s256_pkg::*;

  logic [31:0] wk;
  logic [31:0] t1;
  logic [31:0] t2;

  // rd[0] = w[t-16] (w[t] for t < 16), rd[1] = w[t-15], rd[2] = w[t-7], rd[3] = w[t-2]
  always_comb begin
    if (ctl.sidx[5:4] == 2'b00) begin
      wt = rd[0];
    end else begin
      wt = rd[0] + ssig0(rd[1]) + rd[2] + ssig1(rd[3]);
    end
    t1 = v[7] + bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6])) + wk;
    t2 = bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.sched) begin
      wk <= wt + K[ctl.sidx];
    end
    if (ctl.load) begin
      v <= h;
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

[rtl/sha256_stream_hasher.sv]
// SHA-256 over a byte stream. Each transfer on the msg channel appends msg_byte when
// has_byte is set and closes the message when end_of_message is set; the eight digest
// words then leave on the digest channel, word 0 first, and the hasher starts a new
// message. Bytes are taken back to back while a block is filling. The 64th byte of a
// block starts a compression (load, 65 schedule/round steps, final add), during which
// msg_ready is low: one round unit runs one round a cycle, fed from the block memory.
// At end of message, padding writes one word a cycle up to the end of the block,
// then compresses; when the length does not fit, a second pad block and a second
// compression follow. The digest then takes eight transfers.
module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        msg_valid,
  output logic        msg_ready,
  input  logic [7:0]  msg_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import s256_pkg::*;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [5:0]  fill_next;
  logic [23:0] part;
  logic [63:0] bitlen;
  logic [3:0]  widx;
  logic        mark_pend;
  logic        len_here;
  logic        pad_after;
  logic        mark_after;
  logic        final_blk;
  logic [6:0]  rnd;
  logic [2:0]  oidx;
  work_t       h;
  work_t       v;

  logic        msg_xfer;
  logic        byte_xfer;
  logic        blk_full;
  logic        dig_xfer;
  logic [31:0] pad_word;
  logic [31:0] wt;
  logic [5:0]  q;
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  rd_addr_t    raddr;
  rd_data_t    rdata;
  rnd_ctl_t    ctl;

  assign msg_ready    = (state == ST_IDLE);
  assign digest_valid = (state == ST_OUT);
  assign msg_xfer     = msg_valid && msg_ready;
  assign byte_xfer    = msg_xfer && has_byte;
  assign blk_full     = byte_xfer && (fill == 6'd63);
  assign dig_xfer     = digest_valid && digest_ready;
  assign fill_next    = byte_xfer ? fill + 6'd1 : fill;

  assign digest_word = h[oidx];
  assign word_index  = oidx;
  assign last_word   = (oidx == 3'd7);

  always_comb begin
    if (mark_pend) begin
      case (fill[1:0])
        2'd0:    pad_word = 32'h8000_0000;
        2'd1:    pad_word = {part[7:0], 8'h80, 16'h0000};
        2'd2:    pad_word = {part[15:0], 8'h80, 8'h00};
        default: pad_word = {part[23:0], 8'h80};
      endcase
    end else if (len_here && widx == 4'd14) begin
      pad_word = bitlen[63:32];
    end else if (len_here && widx == 4'd15) begin
      pad_word = bitlen[31:0];
    end else begin
      pad_word = 32'h0;
    end
  end

  // reads for the next schedule step; none of these hits the word written this cycle
  always_comb begin
    q = (state == ST_LOAD) ? 6'd0 : rnd[5:0] + 6'd1;
    raddr[0] = q[3:0];
    raddr[1] = q[3:0] + 4'd1;
    raddr[2] = q[3:0] + 4'd9;
    raddr[3] = q[3:0] + 4'd14;
    ctl.load  = (state == ST_LOAD);
    ctl.sched = (state == ST_ROUND) && !rnd[6];
    ctl.step  = (state == ST_ROUND) && (rnd != 7'd0);
    ctl.sidx  = rnd[5:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = widx;
    wdata = pad_word;
    unique case (state)
      ST_IDLE: begin
        we    = byte_xfer && (fill[1:0] == 2'd3);
        waddr = fill[5:2];
        wdata = {part, msg_byte};
      end
      ST_PAD: begin
        we = 1'b1;
      end
      ST_ROUND: begin
        we    = ctl.sched && (rnd[5:4] != 2'b00);
        waddr = rnd[3:0];
        wdata = wt;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  s256_wmem u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  s256_round u_rnd (
    .clk (clk),
    .ctl (ctl),
    .h   (h),
    .rd  (rdata),
    .wt  (wt),
    .v   (v)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (blk_full) begin
          state_next = ST_LOAD;
        end else if (msg_xfer && end_of_message) begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (widx == 4'd15) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == 7'd64) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (final_blk) begin
          state_next = ST_OUT;
        end else if (pad_after) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (dig_xfer && last_word) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= 6'd0;
      bitlen    <= 64'd0;
      pad_after <= 1'b0;
      rnd       <= 7'd0;
      oidx      <= 3'd0;
      for (int j = 0; j < 8; j++) begin
        h[j] <= IV[j];
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (byte_xfer) begin
            bitlen <= bitlen + 64'd8;
            part   <= {part[15:0], msg_byte};
          end
          fill <= fill_next;
          if (blk_full) begin
            final_blk  <= 1'b0;
            pad_after  <= end_of_message;
            mark_after <= 1'b1;
          end else if (msg_xfer && end_of_message) begin
            widx      <= fill_next[5:2];
            mark_pend <= 1'b1;
            len_here  <= (fill_next[5:3] != 3'd7);
          end
        end
        ST_PAD: begin
          widx      <= widx + 4'd1;
          mark_pend <= 1'b0;
          if (widx == 4'd15) begin
            fill       <= 6'd0;
            final_blk  <= len_here;
            pad_after  <= !len_here;
            mark_after <= 1'b0;
          end
        end
        ST_LOAD: rnd <= 7'd0;
        ST_ROUND: rnd <= rnd + 7'd1;
        ST_FIN: begin
          for (int j = 0; j < 8; j++) begin
            h[j] <= h[j] + v[j];
          end
          oidx <= 3'd0;
          if (!final_blk && pad_after) begin
            widx      <= 4'd0;
            len_here  <= 1'b1;
            mark_pend <= mark_after;
            pad_after <= 1'b0;
          end
        end
        ST_OUT: begin
          if (dig_xfer) begin
            oidx <= oidx + 3'd1;
            if (last_word) begin
              fill   <= 6'd0;
              bitlen <= 64'd0;
              for (int j = 0; j < 8; j++) begin
                h[j] <= IV[j];
              end
            end
          end
        end
        default: begin
          rnd <= 7'd0;
        end
      endcase
    end
  end

endmodule

[rtl/sha256_stream_hasher_chk.sv]
module sha256_stream_hasher_chk (
  input logic        clk,
  input logic        rst,
  input logic        msg_valid,
  input logic        msg_ready,
  input logic [7:0]  msg_byte,
  input logic        has_byte,
  input logic        end_of_message,
  input logic        digest_valid,
  input logic        digest_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // no new message transfer while a digest is being handed out
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("msg_ready high during digest output");

  a_last: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && !last_word) |=>
      (digest_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest words out of order");

  a_back: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && last_word) |=> msg_ready)
    else $error("not ready for a new message after the digest");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=> (digest_valid && $stable(digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha256_stream_hasher_chk u_chk (.*);
